FILE: rtl/ipmt_pkg.sv
// ----------------------------------------------------------------------------
// ipmt_pkg
// Shared constants, operation codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ipmt_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int KIND_W  = 3;
    localparam int OCC_W   = 5;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SAT_W   = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    localparam logic [KIND_W-1:0] KIND_LKP_PHYS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LKP_VIRT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BIND     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNB_PHYS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNB_VIRT = 3'd4;

    // token handed from cell to cell, one hop per cycle
    typedef struct packed {
        logic              active;    // token present this cycle
        logic              store;     // second pass: write first empty entry
        logic              hit;       // a cell already took the operation
        logic              free_seen; // an empty entry was passed
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  phys;
        logic [KEY_W-1:0]  virt;
        logic [KEY_W-1:0]  partner;
    } tok_t;

endpackage

`default_nettype wire

FILE: rtl/ipmt_cell.sv
// ----------------------------------------------------------------------------
// ipmt_cell
// One table entry plus one token stage; acts on the token passing through.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmt_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire ipmt_pkg::tok_t tok_in,
    output ipmt_pkg::tok_t      tok_out
);
    import ipmt_pkg::*;

    logic [KEY_W-1:0] phys_reg, phys_next;
    logic [KEY_W-1:0] virt_reg, virt_next;
    tok_t             tok_reg, tok_next;
    logic             occ;

    assign occ = (virt_reg != '0);

    always_comb
    begin
        tok_next  = tok_in;
        phys_next = phys_reg;
        virt_next = virt_reg;
        if (tok_in.active && !tok_in.hit)
        begin
            if (tok_in.store)
            begin
                if (!occ)
                begin
                    phys_next    = tok_in.phys;
                    virt_next    = tok_in.virt;
                    tok_next.hit = 1'b1;
                end
            end
            else
            begin
                case (tok_in.kind)
                    KIND_LKP_PHYS:
                    begin
                        if (occ && phys_reg == tok_in.phys)
                        begin
                            tok_next.hit     = 1'b1;
                            tok_next.partner = virt_reg;
                        end
                    end
                    KIND_LKP_VIRT:
                    begin
                        if (virt_reg == tok_in.virt)
                        begin
                            tok_next.hit     = 1'b1;
                            tok_next.partner = phys_reg;
                        end
                    end
                    KIND_BIND:
                    begin
                        if (!occ)
                            tok_next.free_seen = 1'b1;
                        else if (virt_reg == tok_in.virt)
                        begin
                            phys_next    = tok_in.phys;
                            tok_next.hit = 1'b1;
                        end
                        else if (phys_reg == tok_in.phys)
                        begin
                            virt_next    = tok_in.virt;
                            tok_next.hit = 1'b1;
                        end
                    end
                    KIND_UNB_PHYS:
                    begin
                        if (occ && phys_reg == tok_in.phys)
                        begin
                            phys_next    = '0;
                            virt_next    = '0;
                            tok_next.hit = 1'b1;
                        end
                    end
                    KIND_UNB_VIRT:
                    begin
                        if (virt_reg == tok_in.virt)
                        begin
                            phys_next    = '0;
                            virt_next    = '0;
                            tok_next.hit = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phys_reg <= '0;
            virt_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            phys_reg <= phys_next;
            virt_reg <= virt_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: rtl/interface_pair_map_table_core.sv
// ----------------------------------------------------------------------------
// interface_pair_map_table_core
// Table of physical/virtual interface index pairs held in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_stall, kind, physical_index,     | in
//          | virtual_index                                 |
//  output  | out_valid, out_stall, success, partner_index, | out
//          | occupied_entries                              |
//
// One item at a time: no new item is taken while one is in flight. An
// operation token walks the ENTRIES cells, one cell per cycle; a bind that
// stores into a free entry walks the chain twice. Refused items (zero key,
// unused kind) are answered without a walk.
// Reset clears every entry and the count at once; no clearing pass.
// The next item is taken as soon as the previous result sits in the output
// register, so out_stall only holds the block while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module interface_pair_map_table_core (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  [ipmt_pkg::KIND_W-1:0]   kind,
    input  wire  [ipmt_pkg::KEY_W-1:0]    physical_index,
    input  wire  [ipmt_pkg::KEY_W-1:0]    virtual_index,
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic                          success,
    output logic [ipmt_pkg::KEY_W-1:0]    partner_index,
    output logic [ipmt_pkg::OCC_W-1:0]    occupied_entries
);
    import ipmt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // token chain: chain[0] is the launch register, chain[ENTRIES] the tail
    tok_t chain [ENTRIES+1];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            ipmt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (chain[g]),
                .tok_out (chain[g+1])
            );
        end
    endgenerate

    logic [1:0]       state_reg, state_next;
    tok_t             launch_reg, launch_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_success_reg, pend_success_next;
    logic [KEY_W-1:0] pend_partner_reg, pend_partner_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_success_reg, out_success_next;
    logic [KEY_W-1:0] out_partner_reg, out_partner_next;
    logic [OCC_W-1:0] out_occ_reg, out_occ_next;

    tok_t             tail;
    logic             refused;
    logic             is_unbind;
    logic             out_free;
    logic [SAT_W-1:0] count_wide;

    assign chain[0]   = launch_reg;
    assign tail       = chain[ENTRIES];
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign count_wide = SAT_W'(count_reg);
    assign is_unbind  = kind inside {KIND_UNB_PHYS, KIND_UNB_VIRT};

    // items answered without a walk: zero keys and unused kinds
    always_comb
    begin
        case (kind)
            KIND_LKP_PHYS: refused = (physical_index == '0);
            KIND_LKP_VIRT: refused = (virtual_index == '0);
            KIND_BIND:     refused = (physical_index == '0) || (virtual_index == '0);
            KIND_UNB_PHYS: refused = (physical_index == '0);
            KIND_UNB_VIRT: refused = (virtual_index == '0);
            default:       refused = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        launch_next       = '0;
        count_next        = count_reg;
        pend_success_next = pend_success_reg;
        pend_partner_next = pend_partner_reg;
        out_valid_next    = out_valid_reg;
        out_success_next  = out_success_reg;
        out_partner_next  = out_partner_reg;
        out_occ_next      = out_occ_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (refused)
                    begin
                        pend_success_next = is_unbind;
                        pend_partner_next = '0;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        launch_next.active = 1'b1;
                        launch_next.kind   = kind;
                        launch_next.phys   = physical_index;
                        launch_next.virt   = virtual_index;
                        state_next         = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (tail.active)
                begin
                    if (!tail.store && tail.kind == KIND_BIND && !tail.hit &&
                        tail.free_seen)
                    begin
                        // no key matched: second walk stores into first empty entry
                        launch_next       = tail;
                        launch_next.store = 1'b1;
                    end
                    else
                    begin
                        case (tail.kind)
                            KIND_UNB_PHYS, KIND_UNB_VIRT:
                            begin
                                pend_success_next = 1'b1;
                                if (tail.hit && count_reg != '0)
                                    count_next = count_reg - 1'b1;
                            end
                            KIND_BIND:
                            begin
                                pend_success_next = tail.hit;
                                if (tail.store && tail.hit &&
                                    count_reg < CNT_W'(ENTRIES))
                                    count_next = count_reg + 1'b1;
                            end
                            default:
                                pend_success_next = tail.hit;
                        endcase
                        pend_partner_next = tail.partner;
                        state_next        = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_success_next = pend_success_reg;
                    out_partner_next = pend_partner_reg;
                    out_occ_next     = (count_wide > SAT_W'(31)) ? OCC_W'(31)
                                                                 : count_wide[OCC_W-1:0];
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_success_reg <= pend_success_next;
        pend_partner_reg <= pend_partner_next;
        out_success_reg  <= out_success_next;
        out_partner_reg  <= out_partner_next;
        out_occ_reg      <= out_occ_next;
    end

    assign out_valid        = out_valid_reg;
    assign success          = out_success_reg;
    assign partner_index    = out_partner_reg;
    assign occupied_entries = out_occ_reg;

endmodule

`default_nettype wire

FILE: tb/sv/interface_pair_map_table_checker.sv
// ----------------------------------------------------------------------------
// interface_pair_map_table_checker
// Watches both channels of the pair table, predicts each result and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module interface_pair_map_table_checker
    import ipmt_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire                in_stall,
    input  wire  [KIND_W-1:0]  kind,
    input  wire  [KEY_W-1:0]   physical_index,
    input  wire  [KEY_W-1:0]   virtual_index,
    input  wire                out_valid,
    input  wire                out_stall,
    input  wire                success,
    input  wire  [KEY_W-1:0]   partner_index,
    input  wire  [OCC_W-1:0]   occupied_entries,
    output int                 fail_count,
    output int                 results_awaited,
    output int                 results_checked,
    output int                 full_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OCC_MAX = (1 << OCC_W) - 1;

    typedef struct packed {
        logic              success;
        logic [KEY_W-1:0]  partner;
        logic [OCC_W-1:0]  occupied;
    } pair_result_t;

    // shadow copy of the table
    logic [KEY_W-1:0] phys_key [ENTRIES];
    logic [KEY_W-1:0] virt_key [ENTRIES];
    int               occupancy;

    pair_result_t     awaited_results [$];

    // applies one operation to the shadow table, returns the expected result
    function automatic pair_result_t apply_table_op(input logic [KIND_W-1:0] k,
                                                    input logic [KEY_W-1:0]  p,
                                                    input logic [KEY_W-1:0]  v);
        pair_result_t r;
        int           free_slot;
        bit           have_free;
        bit           done;
        r         = '0;
        free_slot = 0;
        have_free = 1'b0;
        done      = 1'b0;
        case (k)
            KIND_LKP_PHYS:
                if (p != '0)
                    for (int i = 0; i < ENTRIES; i++)
                        if (!done && virt_key[i] != '0 && phys_key[i] == p)
                        begin
                            r.partner = virt_key[i];
                            r.success = 1'b1;
                            done      = 1'b1;
                        end
            KIND_LKP_VIRT:
                if (v != '0)
                    for (int i = 0; i < ENTRIES; i++)
                        if (!done && virt_key[i] == v)
                        begin
                            r.partner = phys_key[i];
                            r.success = 1'b1;
                            done      = 1'b1;
                        end
            KIND_BIND:
                if (p != '0 && v != '0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (done)
                            continue;
                        if (virt_key[i] == '0)
                        begin
                            if (!have_free)
                            begin
                                free_slot = i;
                                have_free = 1'b1;
                            end
                        end
                        else if (virt_key[i] == v)
                        begin
                            phys_key[i] = p;
                            done        = 1'b1;
                        end
                        else if (phys_key[i] == p)
                        begin
                            virt_key[i] = v;
                            done        = 1'b1;
                        end
                    end
                    if (!done && have_free)
                    begin
                        phys_key[free_slot] = p;
                        virt_key[free_slot] = v;
                        if (occupancy < ENTRIES)
                            occupancy++;
                        done = 1'b1;
                    end
                    else if (!done)
                        full_refusals++;
                    r.success = done;
                end
            KIND_UNB_PHYS, KIND_UNB_VIRT:
            begin
                r.success = 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                    if (!done && virt_key[i] != '0 &&
                        ((k == KIND_UNB_PHYS && p != '0 && phys_key[i] == p) ||
                         (k == KIND_UNB_VIRT && virt_key[i] == v)))
                    begin
                        phys_key[i] = '0;
                        virt_key[i] = '0;
                        if (occupancy > 0)
                            occupancy--;
                        done = 1'b1;
                    end
            end
            default: ;
        endcase
        r.occupied = (occupancy > OCC_MAX) ? OCC_MAX[OCC_W-1:0] : occupancy[OCC_W-1:0];
        return r;
    endfunction

    function automatic void report_field(input string name, input logic [KEY_W-1:0] want,
                                         input logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pair_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                phys_key[i] = '0;
                virt_key[i] = '0;
            end
            occupancy = 0;
            awaited_results.delete();
            results_awaited = 0;
        end
        else
        begin
            // a result leaving now belongs to an item taken at an earlier edge
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %0b/%0h/%0d",
                             $time, success, partner_index, occupied_entries);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    report_field("success", KEY_W'(want.success), KEY_W'(success));
                    report_field("partner_index", want.partner, partner_index);
                    report_field("occupied_entries", KEY_W'(want.occupied),
                                 KEY_W'(occupied_entries));
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_table_op(kind, physical_index, virtual_index));
            results_awaited = awaited_results.size();
        end
    end

    initial
    begin
        fail_count      = 0;
        results_awaited = 0;
        results_checked = 0;
        full_refusals   = 0;
    end

endmodule

`default_nettype wire

FILE: tb/sv/interface_pair_map_table_core_tb.sv
// ----------------------------------------------------------------------------
// interface_pair_map_table_core_tb
// Stimulus and verdict for the interface pair map table.
// A directed opener hits empty-table lookups, zero keys, all-ones keys,
// rewrites by either key, unused kinds and unbinds with nothing to clear.
// Random sequences then work a small key pool and repeatedly fill the table
// past full and empty it again, with random idling on both channels, long
// output holds and full drains mid-run. A checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module interface_pair_map_table_core_tb;
    import ipmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kinds the block must treat as no operation
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam int ITEM_TARGET  = 800;
    localparam int QUIET_AFTER  = 720;   // no idling from here to the end
    localparam int LONG_HOLD    = 80;    // cycles the receiver holds off
    localparam int POOL_SIZE    = 12;    // fewer than ENTRIES, pool alone never fills
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

    logic               clk              = 1'b0;
    logic               rst_n            = 1'b0;
    logic               in_valid         = 1'b0;
    logic               in_stall;
    logic [KIND_W-1:0]  kind             = KIND_LKP_PHYS;
    logic [KEY_W-1:0]   physical_index   = '0;
    logic [KEY_W-1:0]   virtual_index    = '0;
    logic               out_valid;
    logic               out_stall        = 1'b0;
    logic               success;
    logic [KEY_W-1:0]   partner_index;
    logic [OCC_W-1:0]   occupied_entries;

    int fail_count;
    int results_awaited;
    int results_checked;
    int full_refusals;

    int items_sent = 0;
    bit quiet      = 1'b0;

    // long holds: stimulus bumps hold_asks, receiver answers with hold_done
    int hold_asks  = 0;
    int hold_done  = 0;
    int hold_left  = 0;
    int burst_left = 0;

    logic [KEY_W-1:0] phys_pool [POOL_SIZE];
    logic [KEY_W-1:0] virt_pool [POOL_SIZE];

    always #4 clk = ~clk;

    interface_pair_map_table_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .physical_index   (physical_index),
        .virtual_index    (virtual_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .success          (success),
        .partner_index    (partner_index),
        .occupied_entries (occupied_entries)
    );

    interface_pair_map_table_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .physical_index   (physical_index),
        .virtual_index    (virtual_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .success          (success),
        .partner_index    (partner_index),
        .occupied_entries (occupied_entries),
        .fail_count       (fail_count),
        .results_awaited  (results_awaited),
        .results_checked  (results_checked),
        .full_refusals    (full_refusals)
    );

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, long holds on request, calm at the end
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  = 0;
            burst_left = 0;
        end
        else if (hold_asks != hold_done)
        begin
            hold_done = hold_asks;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // nonzero random key; every bit sees both values over the run
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        if (k == '0)
            k = 1;
        return k;
    endfunction

    // offers one item and holds it until the block takes it; valid stays
    // high afterwards so back-to-back items need no second assignment
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] p,
                             input logic [KEY_W-1:0] v);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        physical_index <= p;
        virtual_index  <= v;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (items_sent >= QUIET_AFTER)
            quiet = 1'b1;
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_awaited != 0)
            @(posedge clk);
    endtask

    // well-formed traffic on a small key pool, with some noise mixed in
    task automatic pool_burst(input int count);
        int               r;
        int               a;
        int               b;
        logic [KIND_W-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            a = $urandom_range(0, POOL_SIZE - 1);
            b = $urandom_range(0, POOL_SIZE - 1);
            if (r < 30)
                send_item(KIND_BIND, phys_pool[a], virt_pool[b]);
            else if (r < 45)
                send_item(KIND_LKP_PHYS, phys_pool[a], fresh_key());
            else if (r < 60)
                send_item(KIND_LKP_VIRT, fresh_key(), virt_pool[b]);
            else if (r < 70)
                send_item(KIND_UNB_PHYS, phys_pool[a], fresh_key());
            else if (r < 80)
                send_item(KIND_UNB_VIRT, fresh_key(), virt_pool[b]);
            else if (r < 86)
            begin
                // one key zeroed: refused or ignored depending on the kind
                k = KIND_W'($urandom_range(KIND_UNB_VIRT, KIND_LKP_PHYS));
                if ($urandom_range(0, 1) == 1)
                    send_item(k, '0, virt_pool[b]);
                else
                    send_item(k, phys_pool[a], '0);
            end
            else if (r < 90)
                send_item(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
                          phys_pool[a], virt_pool[b]);
            else
                send_item(KIND_W'($urandom_range(KIND_UNB_VIRT, KIND_LKP_PHYS)),
                          $urandom, $urandom);
        end
    endtask

    // binds one pair more than fits, probes some, then unbinds them all
    task automatic fill_and_empty();
        logic [KEY_W-1:0] p_keys [ENTRIES + 1];
        logic [KEY_W-1:0] v_keys [ENTRIES + 1];
        int               j;
        for (int i = 0; i <= ENTRIES; i++)
        begin
            p_keys[i] = fresh_key();
            v_keys[i] = fresh_key();
            send_item(KIND_BIND, p_keys[i], v_keys[i]);
        end
        for (int i = 0; i < 8; i++)
        begin
            j = $urandom_range(0, ENTRIES);
            if ($urandom_range(0, 1) == 1)
                send_item(KIND_LKP_PHYS, p_keys[j], fresh_key());
            else
                send_item(KIND_LKP_VIRT, fresh_key(), v_keys[j]);
        end
        for (int i = 0; i <= ENTRIES; i++)
            if ($urandom_range(0, 1) == 1)
                send_item(KIND_UNB_PHYS, p_keys[i], fresh_key());
            else
                send_item(KIND_UNB_VIRT, fresh_key(), v_keys[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int next_hold;
        int next_drain;
        next_hold  = 150;
        next_drain = 300;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            phys_pool[i] = fresh_key();
            virt_pool[i] = fresh_key();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: lookups miss, zero keys refused, unbind at count zero
        send_item(KIND_LKP_PHYS, 32'h0000_0005, 32'h0000_0000);
        send_item(KIND_LKP_VIRT, 32'h0000_0000, 32'h0000_0005);
        send_item(KIND_LKP_PHYS, 32'h0000_0000, 32'h0000_0007);
        send_item(KIND_LKP_VIRT, 32'h0000_0007, 32'h0000_0000);
        send_item(KIND_BIND,     32'h0000_0000, 32'h0000_0007);
        send_item(KIND_BIND,     32'h0000_0007, 32'h0000_0000);
        send_item(KIND_UNB_PHYS, 32'h0000_0009, 32'h0000_0000);
        send_item(KIND_UNB_VIRT, 32'h0000_0009, 32'h0000_0000);
        // all-ones and smallest keys, both directions
        send_item(KIND_BIND,     32'hFFFF_FFFF, 32'h0000_0001);
        send_item(KIND_BIND,     32'h0000_0001, 32'hFFFF_FFFF);
        send_item(KIND_LKP_PHYS, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(KIND_LKP_VIRT, 32'h0000_0000, 32'hFFFF_FFFF);
        // rewrite by matching virtual key, then by matching physical key
        send_item(KIND_BIND,     32'hAAAA_5555, 32'h0000_0001);
        send_item(KIND_BIND,     32'h0000_0001, 32'h5555_AAAA);
        send_item(KIND_LKP_PHYS, 32'hAAAA_5555, 32'hFFFF_FFFF);
        send_item(KIND_LKP_VIRT, 32'hFFFF_FFFF, 32'h5555_AAAA);
        // unused kinds leave everything alone
        send_item(KIND_SPARE_FIRST, 32'hAAAA_5555, 32'h0000_0001);
        send_item(KIND_SPARE_LAST,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unbinds: no match, by virtual, by physical, then on an empty table
        send_item(KIND_UNB_PHYS, 32'h1234_5678, 32'h0000_0000);
        send_item(KIND_UNB_VIRT, 32'h0000_0000, 32'h5555_AAAA);
        send_item(KIND_UNB_PHYS, 32'hAAAA_5555, 32'h0000_0000);
        send_item(KIND_LKP_VIRT, 32'h0000_0000, 32'h0000_0001);
        send_item(KIND_UNB_VIRT, 32'h0000_0000, 32'h0000_0001);

        // random sequences, with pressure points along the way
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_hold && !quiet)
            begin
                hold_asks++;   // output held long; the block backs up onto its input
                next_hold += 300;
            end
            if (items_sent >= next_drain)
            begin
                wait_for_drain();
                next_drain += 300;
            end
            if ($urandom_range(0, 5) == 0)
                fill_and_empty();
            else
                pool_burst(20);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items, %0d results checked, %0d binds refused on a full table,",
                 items_sent, results_checked, full_refusals);
        $display("%0d long output holds and random idling on both channels.", hold_asks);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Timed out with %0d results still awaited.", results_awaited);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/ipmt_pkg.sv
rtl/ipmt_cell.sv
rtl/interface_pair_map_table_core.sv
tb/sv/interface_pair_map_table_checker.sv
tb/sv/interface_pair_map_table_core_tb.sv
